### hw/rtl/acmd_pkg.sv
package acmd_pkg;

  localparam int unsigned NumDigits = 8;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgTicksPerTenth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBuzzOnTicks    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgBuzzPeriodTicks = 2'd2;

  localparam logic [7:0]  RstTicksPerTenth   = 8'd50;
  localparam logic [15:0] RstBuzzOnTicks     = 16'd250;
  localparam logic [15:0] RstBuzzPeriodTicks = 16'd500;

  // command codes
  localparam logic CmdTick = 1'b0;
  localparam logic CmdKey  = 1'b1;

  // key codes
  localparam logic [2:0] KeyNone        = 3'd0;
  localparam logic [2:0] KeyMode        = 3'd1;
  localparam logic [2:0] KeyHourUp      = 3'd2;
  localparam logic [2:0] KeyMinuteUp    = 3'd3;
  localparam logic [2:0] KeyConfirm     = 3'd4;
  localparam logic [2:0] KeyAlarmHour   = 3'd5;
  localparam logic [2:0] KeyAlarmMinute = 3'd6;

  localparam logic [7:0] GlyphDash  = 8'hbf;
  localparam logic [7:0] GlyphBlank = 8'hff;

  typedef enum logic [2:0] {
    ModeNormal      = 3'd0,
    ModeSetHour     = 3'd1,
    ModeSetMinute   = 3'd2,
    ModeAlarmHour   = 3'd3,
    ModeAlarmMinute = 3'd4
  } mode_e;

  typedef struct packed {
    logic [7:0]  ticks_per_tenth;
    logic [15:0] buzz_on_ticks;
    logic [15:0] buzz_period_ticks;
  } cfg_t;

  typedef struct packed {
    logic       command;
    logic [2:0] key_code;
    logic [7:0] rtc_second_byte;
    logic [7:0] rtc_minute_byte;
    logic [7:0] rtc_hour_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] segment_pins;
    logic [7:0] digit_enable;
    logic       buzz_drive;
    logic       work_led;
    logic [2:0] clock_mode;
    logic       rtc_write;
    logic [5:0] write_hour_bcd;
    logic [6:0] write_minute_bcd;
  } result_t;

  // what the digit mux needs to pick a glyph
  typedef struct packed {
    mode_e      mode;
    logic [4:0] cur_hour;
    logic [5:0] cur_minute;
    logic [5:0] cur_second;
    logic [4:0] alm_hour;
    logic [5:0] alm_minute;
    logic       blink_phase;
    logic [2:0] scan_index;
  } view_t;

  function automatic logic [7:0] glyph(logic [3:0] d);
    logic [7:0] g;
    unique case (d)
      4'd0:    g = 8'hc0;
      4'd1:    g = 8'hf9;
      4'd2:    g = 8'ha4;
      4'd3:    g = 8'hb0;
      4'd4:    g = 8'h99;
      4'd5:    g = 8'h92;
      4'd6:    g = 8'h82;
      4'd7:    g = 8'hf8;
      4'd8:    g = 8'h80;
      4'd9:    g = 8'h90;
      default: g = GlyphBlank;
    endcase
    return g;
  endfunction

  // binary 0..63 to {tens, ones}
  function automatic logic [6:0] split_dec(logic [5:0] v);
    logic [2:0] tens;
    logic [5:0] rest;
    priority if (v >= 6'd60) begin
      tens = 3'd6; rest = v - 6'd60;
    end else if (v >= 6'd50) begin
      tens = 3'd5; rest = v - 6'd50;
    end else if (v >= 6'd40) begin
      tens = 3'd4; rest = v - 6'd40;
    end else if (v >= 6'd30) begin
      tens = 3'd3; rest = v - 6'd30;
    end else if (v >= 6'd20) begin
      tens = 3'd2; rest = v - 6'd20;
    end else if (v >= 6'd10) begin
      tens = 3'd1; rest = v - 6'd10;
    end else begin
      tens = 3'd0; rest = v;
    end
    return {tens, rest[3:0]};
  endfunction

  // raw BCD byte fields to binary, saturated at limit
  function automatic logic [5:0] bcd_to_bin(logic [2:0] hi, logic [3:0] lo, logic [5:0] limit);
    logic [6:0] v;
    v = {1'b0, hi, 3'b000} + {3'b000, hi, 1'b0} + {3'b000, lo};
    return (v > {1'b0, limit}) ? limit : v[5:0];
  endfunction

endpackage

### hw/rtl/acmd_cfg_regs.sv
module acmd_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [acmd_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [acmd_pkg::CfgDataW-1:0]    cfg_wdata_i,
  output acmd_pkg::cfg_t                   cfg_o
);

  acmd_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        acmd_pkg::CfgTicksPerTenth:   cfg_d.ticks_per_tenth   = cfg_wdata_i[7:0];
        acmd_pkg::CfgBuzzOnTicks:     cfg_d.buzz_on_ticks     = cfg_wdata_i;
        acmd_pkg::CfgBuzzPeriodTicks: cfg_d.buzz_period_ticks = cfg_wdata_i;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ticks_per_tenth   <= acmd_pkg::RstTicksPerTenth;
      cfg_q.buzz_on_ticks     <= acmd_pkg::RstBuzzOnTicks;
      cfg_q.buzz_period_ticks <= acmd_pkg::RstBuzzPeriodTicks;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hw/rtl/acmd_in_stage.sv
module acmd_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  acmd_pkg::item_t item_i,
  input  logic            advance_i,
  output logic            item_valid_o,
  output acmd_pkg::item_t item_o
);

  logic            valid_q, valid_d;
  logic            load;
  acmd_pkg::item_t item_q;

  assign in_stall_o = valid_q & ~advance_i;
  assign load       = in_valid_i & ~in_stall_o;
  assign valid_d    = load | (valid_q & ~advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

### hw/rtl/acmd_digit_mux.sv
module acmd_digit_mux (
  input  acmd_pkg::view_t view_i,
  output logic [7:0]      segments_o
);

  localparam logic [2:0] PosHourTens   = 3'd0;
  localparam logic [2:0] PosHourOnes   = 3'd1;
  localparam logic [2:0] PosMinuteTens = 3'd3;
  localparam logic [2:0] PosMinuteOnes = 3'd4;
  localparam logic [2:0] PosSecondTens = 3'd6;
  localparam logic [2:0] PosSecondOnes = 3'd7;

  logic       alarm_view, hide_hour, hide_minute;
  logic [5:0] hour, minute, second;
  logic [6:0] hour_dec, minute_dec, second_dec;

  always_comb begin
    alarm_view  = (view_i.mode == acmd_pkg::ModeAlarmHour) ||
                  (view_i.mode == acmd_pkg::ModeAlarmMinute);
    hour        = alarm_view ? {1'b0, view_i.alm_hour} : {1'b0, view_i.cur_hour};
    minute      = alarm_view ? view_i.alm_minute : view_i.cur_minute;
    second      = alarm_view ? 6'd0 : view_i.cur_second;
    hide_hour   = ((view_i.mode == acmd_pkg::ModeSetHour) ||
                   (view_i.mode == acmd_pkg::ModeAlarmHour)) && !view_i.blink_phase;
    hide_minute = ((view_i.mode == acmd_pkg::ModeSetMinute) ||
                   (view_i.mode == acmd_pkg::ModeAlarmMinute)) && !view_i.blink_phase;
    hour_dec    = acmd_pkg::split_dec(hour);
    minute_dec  = acmd_pkg::split_dec(minute);
    second_dec  = acmd_pkg::split_dec(second);

    unique case (view_i.scan_index)
      PosHourTens:   segments_o = hide_hour ? acmd_pkg::GlyphBlank
                                            : acmd_pkg::glyph({1'b0, hour_dec[6:4]});
      PosHourOnes:   segments_o = hide_hour ? acmd_pkg::GlyphBlank
                                            : acmd_pkg::glyph(hour_dec[3:0]);
      PosMinuteTens: segments_o = hide_minute ? acmd_pkg::GlyphBlank
                                              : acmd_pkg::glyph({1'b0, minute_dec[6:4]});
      PosMinuteOnes: segments_o = hide_minute ? acmd_pkg::GlyphBlank
                                              : acmd_pkg::glyph(minute_dec[3:0]);
      PosSecondTens: segments_o = acmd_pkg::glyph({1'b0, second_dec[6:4]});
      PosSecondOnes: segments_o = acmd_pkg::glyph(second_dec[3:0]);
      default:       segments_o = acmd_pkg::GlyphDash;  // separators
    endcase
  end

endmodule

### hw/rtl/acmd_core.sv
module acmd_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  acmd_pkg::item_t   item_i,
  input  acmd_pkg::cfg_t    cfg_i,
  input  logic [7:0]        segments_i,
  output acmd_pkg::view_t   view_o,
  output acmd_pkg::result_t result_o
);

  acmd_pkg::mode_e mode_q, mode_d;
  logic [4:0]  cur_hour_q, cur_hour_d;
  logic [5:0]  cur_minute_q, cur_minute_d;
  logic [5:0]  cur_second_q, cur_second_d;
  logic [4:0]  alm_hour_q, alm_hour_d;
  logic [5:0]  alm_minute_q, alm_minute_d;
  logic        alm_enabled_q, alm_enabled_d;
  logic        ringing_q, ringing_d;
  logic [7:0]  tick_count_q, tick_count_d;
  logic [3:0]  tenth_count_q, tenth_count_d;
  logic        blink_q, blink_d;
  logic        led_q, led_d;
  logic [2:0]  scan_q, scan_d;
  logic [15:0] buzz_count_q, buzz_count_d;
  logic        buzz_level_q, buzz_level_d;
  logic [7:0]  shown_seg_q, shown_seg_d;
  logic [7:0]  shown_sel_q, shown_sel_d;

  logic [7:0]  tick_inc;
  logic [3:0]  tenth_inc;
  logic [15:0] buzz_inc;
  logic        rtc_wr;
  logic [6:0]  hour_dec, minute_dec;

  assign view_o = '{mode:        mode_q,
                    cur_hour:    cur_hour_q,
                    cur_minute:  cur_minute_q,
                    cur_second:  cur_second_q,
                    alm_hour:    alm_hour_q,
                    alm_minute:  alm_minute_q,
                    blink_phase: blink_q,
                    scan_index:  scan_q};

  always_comb begin
    mode_d        = mode_q;
    cur_hour_d    = cur_hour_q;
    cur_minute_d  = cur_minute_q;
    cur_second_d  = cur_second_q;
    alm_hour_d    = alm_hour_q;
    alm_minute_d  = alm_minute_q;
    alm_enabled_d = alm_enabled_q;
    ringing_d     = ringing_q;
    tick_count_d  = tick_count_q;
    tenth_count_d = tenth_count_q;
    blink_d       = blink_q;
    led_d         = led_q;
    scan_d        = scan_q;
    buzz_count_d  = buzz_count_q;
    buzz_level_d  = buzz_level_q;
    shown_seg_d   = shown_seg_q;
    shown_sel_d   = shown_sel_q;
    rtc_wr        = 1'b0;
    tick_inc      = tick_count_q + 8'd1;
    tenth_inc     = tenth_count_q + 4'd1;
    buzz_inc      = buzz_count_q + 16'd1;

    if (item_i.command == acmd_pkg::CmdTick) begin
      // digit from the state before this tick
      shown_seg_d = segments_i;
      shown_sel_d = 8'd1 << scan_q;
      scan_d      = scan_q + 3'd1;

      if (tick_inc >= cfg_i.ticks_per_tenth) begin
        tick_count_d  = 8'd0;
        tenth_count_d = tenth_inc;
        if (tenth_inc == 4'd0 || tenth_inc == 4'd5 ||
            tenth_inc == 4'd10 || tenth_inc == 4'd15) begin
          blink_d = ~blink_q;
        end
        if (tenth_inc >= 4'd10) begin
          // second boundary
          tenth_count_d = 4'd0;
          led_d         = ~led_q;
          if (mode_q == acmd_pkg::ModeNormal) begin
            cur_second_d = acmd_pkg::bcd_to_bin(item_i.rtc_second_byte[6:4],
                                                item_i.rtc_second_byte[3:0], 6'd59);
            cur_minute_d = acmd_pkg::bcd_to_bin(item_i.rtc_minute_byte[6:4],
                                                item_i.rtc_minute_byte[3:0], 6'd59);
            cur_hour_d   = 5'(acmd_pkg::bcd_to_bin({1'b0, item_i.rtc_hour_byte[5:4]},
                                                   item_i.rtc_hour_byte[3:0], 6'd23));
          end
          if (alm_enabled_q && cur_hour_d == alm_hour_q &&
              cur_minute_d == alm_minute_q && cur_second_d == 6'd0) begin
            ringing_d = 1'b1;
          end
        end
      end else begin
        tick_count_d = tick_inc;
      end

      if (ringing_d) begin
        if (buzz_inc < cfg_i.buzz_on_ticks) begin
          buzz_count_d = buzz_inc;
          buzz_level_d = 1'b1;
        end else if (buzz_inc < cfg_i.buzz_period_ticks) begin
          buzz_count_d = buzz_inc;
          buzz_level_d = 1'b0;
        end else begin
          buzz_count_d = 16'd0;  // restart, level held
        end
      end else begin
        buzz_count_d = 16'd0;
        buzz_level_d = 1'b0;
      end
    end else if (item_i.key_code != acmd_pkg::KeyNone) begin
      if (ringing_q) begin
        // any key just silences the alarm
        ringing_d    = 1'b0;
        buzz_level_d = 1'b0;
      end else begin
        unique case (item_i.key_code)
          acmd_pkg::KeyMode: begin
            unique case (mode_q)
              acmd_pkg::ModeNormal:  mode_d = acmd_pkg::ModeSetHour;
              acmd_pkg::ModeSetHour: mode_d = acmd_pkg::ModeSetMinute;
              default:               mode_d = acmd_pkg::ModeNormal;
            endcase
          end
          acmd_pkg::KeyHourUp: begin
            if (mode_q == acmd_pkg::ModeSetHour) begin
              cur_hour_d = (cur_hour_q >= 5'd23) ? 5'd0 : cur_hour_q + 5'd1;
            end
          end
          acmd_pkg::KeyMinuteUp: begin
            if (mode_q == acmd_pkg::ModeSetMinute) begin
              cur_minute_d = (cur_minute_q >= 6'd59) ? 6'd0 : cur_minute_q + 6'd1;
            end
          end
          acmd_pkg::KeyConfirm: begin
            if (mode_q == acmd_pkg::ModeSetHour || mode_q == acmd_pkg::ModeSetMinute) begin
              cur_second_d = 6'd0;
              mode_d       = acmd_pkg::ModeNormal;
              rtc_wr       = 1'b1;
            end else if (mode_q == acmd_pkg::ModeAlarmHour ||
                         mode_q == acmd_pkg::ModeAlarmMinute) begin
              alm_enabled_d = 1'b1;
              mode_d        = acmd_pkg::ModeNormal;
            end
          end
          acmd_pkg::KeyAlarmHour: begin
            if (mode_q == acmd_pkg::ModeNormal || mode_q == acmd_pkg::ModeAlarmMinute) begin
              mode_d = acmd_pkg::ModeAlarmHour;
            end else if (mode_q == acmd_pkg::ModeAlarmHour) begin
              alm_hour_d = (alm_hour_q >= 5'd23) ? 5'd0 : alm_hour_q + 5'd1;
            end
          end
          acmd_pkg::KeyAlarmMinute: begin
            if (mode_q == acmd_pkg::ModeNormal || mode_q == acmd_pkg::ModeAlarmHour) begin
              mode_d = acmd_pkg::ModeAlarmMinute;
            end else if (mode_q == acmd_pkg::ModeAlarmMinute) begin
              alm_minute_d = (alm_minute_q >= 6'd59) ? 6'd0 : alm_minute_q + 6'd1;
            end
          end
          default: ;  // unused key code
        endcase
      end
    end

    hour_dec   = acmd_pkg::split_dec({1'b0, cur_hour_d});
    minute_dec = acmd_pkg::split_dec(cur_minute_d);

    result_o.segment_pins     = shown_seg_d;
    result_o.digit_enable     = shown_sel_d;
    result_o.buzz_drive       = buzz_level_d;
    result_o.work_led         = led_d;
    result_o.clock_mode       = mode_d;
    result_o.rtc_write        = rtc_wr;
    result_o.write_hour_bcd   = rtc_wr ? hour_dec[5:0] : 6'd0;
    result_o.write_minute_bcd = rtc_wr ? minute_dec : 7'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= acmd_pkg::ModeNormal;
    end else if (fire_i) begin
      mode_q <= mode_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_hour_q    <= 5'd0;
      cur_minute_q  <= 6'd0;
      cur_second_q  <= 6'd0;
      alm_hour_q    <= 5'd0;
      alm_minute_q  <= 6'd1;
      alm_enabled_q <= 1'b1;
      ringing_q     <= 1'b0;
      tick_count_q  <= 8'd0;
      tenth_count_q <= 4'd0;
      blink_q       <= 1'b1;
      led_q         <= 1'b0;
      scan_q        <= 3'd0;
      buzz_count_q  <= 16'd0;
      buzz_level_q  <= 1'b0;
      shown_seg_q   <= acmd_pkg::GlyphBlank;
      shown_sel_q   <= 8'd0;
    end else if (fire_i) begin
      cur_hour_q    <= cur_hour_d;
      cur_minute_q  <= cur_minute_d;
      cur_second_q  <= cur_second_d;
      alm_hour_q    <= alm_hour_d;
      alm_minute_q  <= alm_minute_d;
      alm_enabled_q <= alm_enabled_d;
      ringing_q     <= ringing_d;
      tick_count_q  <= tick_count_d;
      tenth_count_q <= tenth_count_d;
      blink_q       <= blink_d;
      led_q         <= led_d;
      scan_q        <= scan_d;
      buzz_count_q  <= buzz_count_d;
      buzz_level_q  <= buzz_level_d;
      shown_seg_q   <= shown_seg_d;
      shown_sel_q   <= shown_sel_d;
    end
  end

endmodule

### hw/rtl/alarm_clock_mode_and_display_control.sv
// Channel  Direction  Handshake              Payload
// in       request    in_valid_i/in_stall_o  command, key_code, rtc second/minute/hour bytes
// out      request    out_valid_o/out_stall_i segment_pins .. write_minute_bcd
// cfg      write      cfg_we_i               cfg_index_i, cfg_wdata_i
//
// One request per cycle sustained while out_stall_i is low; a result is registered once its request
// is taken (input register, then state update and result register in one pass).
// Asynchronous active-low reset sets state and counters to their reset values and clears both valid flags.
// A stalled result holds; one further request is taken into the input register, after which
// in_stall_o follows out_stall_i.
module alarm_clock_mode_and_display_control (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request in
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          command_i,
  input  logic [2:0]                    key_code_i,
  input  logic [7:0]                    rtc_second_byte_i,
  input  logic [7:0]                    rtc_minute_byte_i,
  input  logic [7:0]                    rtc_hour_byte_i,
  // result out
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    segment_pins_o,
  output logic [7:0]                    digit_enable_o,
  output logic                          buzz_drive_o,
  output logic                          work_led_o,
  output logic [2:0]                    clock_mode_o,
  output logic                          rtc_write_o,
  output logic [5:0]                    write_hour_bcd_o,
  output logic [6:0]                    write_minute_bcd_o,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [acmd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [acmd_pkg::CfgDataW-1:0] cfg_wdata_i
);

  acmd_pkg::cfg_t    cfg;
  acmd_pkg::item_t   in_item, item;
  acmd_pkg::view_t   view;
  acmd_pkg::result_t result, result_q;
  logic              item_valid, advance, fire;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        segments;

  assign in_item = '{command:         command_i,
                     key_code:        key_code_i,
                     rtc_second_byte: rtc_second_byte_i,
                     rtc_minute_byte: rtc_minute_byte_i,
                     rtc_hour_byte:   rtc_hour_byte_i};

  // result register is free, or being emptied this cycle
  assign advance     = ~out_valid_q | ~out_stall_i;
  assign fire        = item_valid & advance;
  assign out_valid_d = fire | (out_valid_q & ~advance);

  acmd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  acmd_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .item_i       (in_item),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  // glyph for the digit being scanned, from pre-update state
  acmd_digit_mux u_mux (
    .view_i     (view),
    .segments_o (segments)
  );

  // mode control, time keeping, tick/blink/buzzer counters
  acmd_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .item_i     (item),
    .cfg_i      (cfg),
    .segments_i (segments),
    .view_o     (view),
    .result_o   (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      result_q <= result;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign segment_pins_o     = result_q.segment_pins;
  assign digit_enable_o     = result_q.digit_enable;
  assign buzz_drive_o       = result_q.buzz_drive;
  assign work_led_o         = result_q.work_led;
  assign clock_mode_o       = result_q.clock_mode;
  assign rtc_write_o        = result_q.rtc_write;
  assign write_hour_bcd_o   = result_q.write_hour_bcd;
  assign write_minute_bcd_o = result_q.write_minute_bcd;

endmodule

### hw/rtl/acmd_checker.sv
module acmd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] segment_pins_o,
  input logic [7:0] digit_enable_o,
  input logic [2:0] clock_mode_o,
  input logic       rtc_write_o,
  input logic [5:0] write_hour_bcd_o,
  input logic [6:0] write_minute_bcd_o
);

  // at most one digit lit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0(digit_enable_o))
    else $error("digit select not one-hot");

  // no stray write data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !rtc_write_o |-> write_hour_bcd_o == 6'd0 && write_minute_bcd_o == 7'd0)
    else $error("write data without rtc write");

  // confirming a set always returns to normal mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rtc_write_o |-> clock_mode_o == acmd_pkg::ModeNormal)
    else $error("rtc write outside normal mode");

  // written time is valid BCD
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rtc_write_o |-> write_hour_bcd_o[3:0] <= 4'd9 &&
                                   write_minute_bcd_o[3:0] <= 4'd9)
    else $error("bad BCD digit in rtc write");

  // held result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(segment_pins_o) &&
                                   $stable(digit_enable_o))
    else $error("stalled result changed");

endmodule

bind alarm_clock_mode_and_display_control acmd_checker u_checker (.*);
